// ----- rtl/gql_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gql_pkg: shared types and constants for the glyph quad layout block.
// Holds table sizes, command codes, saturation limits and the queue entry type.
// ----------------------------------------------------------------------------
package gql_pkg;

  localparam int KernEntries  = 64;
  localparam int GlyphEntries = 256;
  localparam int KernIdxW     = $clog2(KernEntries);
  localparam int KernCntW     = $clog2(KernEntries + 1);
  localparam int GlyphIdxW    = $clog2(GlyphEntries);

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCALE       = 2'd0,
    CFG_INV_ATLAS   = 2'd1,
    CFG_LINE_HEIGHT = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_KERN  = 2'd1,
    KIND_BEGIN = 2'd2,
    KIND_PLACE = 2'd3
  } kind_t;

  localparam logic signed [23:0] PenMax = 24'sh7FFFFF;
  localparam logic signed [23:0] PenMin = -24'sh800000;
  localparam logic [16:0]        TexMax = 17'h1FFFF;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        code;
    logic [7:0]        second_code;
    logic signed [15:0] position_x;
    logic signed [15:0] position_y;
    logic [7:0]        glyph_width;
    logic [7:0]        glyph_height;
    logic signed [7:0] offset_x;
    logic signed [7:0] offset_y;
    logic [7:0]        advance;
    logic signed [7:0] kern_amount;
  } item_t;

  typedef struct packed {
    logic signed [23:0] quad_left;
    logic signed [23:0] quad_right;
    logic signed [23:0] quad_top;
    logic signed [23:0] quad_bottom;
    logic [16:0]        tex_left;
    logic [16:0]        tex_right;
    logic [16:0]        tex_top;
    logic [16:0]        tex_bottom;
    logic [15:0]        glyph_number;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SEARCH,
    ST_CALC,
    ST_MUL,
    ST_OUT
  } back_state_t;

  // Saturate a signed 42-bit value to signed 24 bits.
  function automatic logic signed [23:0] sat24(input logic signed [41:0] v);
    logic signed [23:0] r;
    if (v > 42'(PenMax)) r = PenMax;
    else if (v < 42'(PenMin)) r = PenMin;
    else r = v[23:0];
    return r;
  endfunction

  // Saturate an unsigned 29-bit texture product.
  function automatic logic [16:0] sat_tex(input logic [28:0] v);
    logic [16:0] r;
    if (v > 29'(TexMax)) r = TexMax;
    else r = v[16:0];
    return r;
  endfunction

endpackage

// ----- rtl/gql_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gql_stream_if: valid/ready channel with a typed payload.
// Used for both the command input and the result output.
// ----------------------------------------------------------------------------
interface gql_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/gql_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gql_front: command intake and two-entry queue.
// Accepts items and buffers them so intake and execution stall independently.
// ----------------------------------------------------------------------------
module gql_front import gql_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_pop,
  output item_t q_item
);

  item_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];

  // Payload storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= in_item;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ----- rtl/gql_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gql_back: command execution.
// Holds the glyph and kerning memories, the pen state, the serial kerning
// search and the scaling multipliers; drives one result register.
// ----------------------------------------------------------------------------
module gql_back import gql_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic         q_valid,
  output logic         q_pop,
  input  item_t        q_item,
  output logic         res_valid,
  input  logic         res_ready,
  output result_t      res_data
);

  // Configuration registers.
  logic [15:0] scale_r, inv_r;
  logic [7:0]  line_h_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= 16'd256;
      inv_r    <= 16'd256;
      line_h_r <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SCALE:       scale_r  <= cfg_data;
        CFG_INV_ATLAS:   inv_r    <= cfg_data;
        CFG_LINE_HEIGHT: line_h_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Glyph memory: {ax12, ay12, w, h, ox, oy, adv}; valid bits give zero reset.
  logic [63:0]             glyph_mem [GlyphEntries];
  logic [GlyphEntries-1:0] gvalid_r;
  logic [63:0]             grd_r;
  logic                    grd_ok_r;
  // Kerning memory: {a, b, amount}.
  logic [23:0]             kern_mem [KernEntries];
  logic [23:0]             krd_r;
  logic [KernCntW-1:0]     kcnt_r;

  back_state_t st_r, st_nxt;
  logic [KernCntW-1:0] kidx_r, kidx_nxt;
  logic [KernIdxW-1:0] kaddr;
  logic                kfound_r, kfound_nxt;
  logic signed [7:0]   kamt_r, kamt_nxt;

  logic signed [23:0] pen_x_r, pen_x_nxt;
  logic signed [17:0] pen_y_r;
  logic [7:0]         prev_r;
  logic               prev_ok_r;
  logic [15:0]        cnt_r;

  // Operand registers for the multiply stage.
  logic signed [24:0] lft_r, rgt_r;
  logic signed [18:0] top_r, bot_r;
  logic [12:0]        tl_r, tr_r, tt_r, tb_r;
  logic               out_v_r;
  result_t            out_r;

  logic        gwr, kwr;
  logic [11:0] g_ax, g_ay;
  logic [7:0]  g_w, g_h, g_adv;
  logic signed [7:0] g_ox, g_oy;
  logic signed [24:0] pen_k, pen_a;

  assign kaddr = kidx_r[KernIdxW-1:0];
  assign {g_ax, g_ay, g_w, g_h, g_ox, g_oy, g_adv} = grd_ok_r ? grd_r : 64'd0;
  assign gwr = (st_r == ST_IDLE) && q_valid && (kind_t'(q_item.kind) == KIND_LOAD);
  assign kwr = (st_r == ST_IDLE) && q_valid && (kind_t'(q_item.kind) == KIND_KERN)
               && (kcnt_r < KernCntW'(KernEntries));

  // Memory write and registered reads.
  always_ff @(posedge clk) begin
    if (gwr) glyph_mem[q_item.code] <= {q_item.position_x[11:0], q_item.position_y[11:0],
                                       q_item.glyph_width, q_item.glyph_height,
                                       q_item.offset_x, q_item.offset_y, q_item.advance};
    if (kwr) kern_mem[kcnt_r[KernIdxW-1:0]] <= {q_item.code, q_item.second_code,
                                                q_item.kern_amount};
    grd_r    <= glyph_mem[q_item.code];
    grd_ok_r <= gvalid_r[q_item.code];
    krd_r    <= kern_mem[kaddr];
  end

  // Pen after kerning, saturated to the pen range; the advance is added later.
  assign pen_k = 25'(pen_x_r) + 25'(kamt_r);
  always_comb begin
    logic signed [23:0] pk;
    pk = (pen_k > 25'(PenMax)) ? PenMax : (pen_k < 25'(PenMin)) ? PenMin : pen_k[23:0];
    pen_a = 25'(pk);
  end

  // Sequencer: next state and search control.
  always_comb begin
    st_nxt     = st_r;
    kidx_nxt   = kidx_r;
    kfound_nxt = kfound_r;
    kamt_nxt   = kamt_r;
    q_pop      = 1'b0;
    pen_x_nxt  = pen_x_r;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (kind_t'(q_item.kind) == KIND_PLACE) begin
            if (!out_v_r || res_ready) begin
              st_nxt     = ST_READ;
              kidx_nxt   = '0;
              kfound_nxt = !prev_ok_r;
              kamt_nxt   = '0;
            end
          end else begin
            q_pop = 1'b1;
          end
        end
      end
      ST_READ: st_nxt = ST_SEARCH;
      ST_SEARCH: begin
        // Each kerning entry is read in ST_READ and compared here; the scan stops at a match or the table end.
        if (kfound_r || kidx_r >= kcnt_r) begin
          st_nxt = ST_CALC;
        end else begin
          if (krd_r[23:16] == prev_r && krd_r[15:8] == q_item.code) begin
            kfound_nxt = 1'b1;
            kamt_nxt   = krd_r[7:0];
          end
          kidx_nxt = kidx_r + 1'b1;
          st_nxt   = ST_READ;
        end
      end
      ST_CALC: st_nxt = ST_MUL;
      ST_MUL: begin
        st_nxt = ST_OUT;
        q_pop  = 1'b1;
      end
      ST_OUT: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      kidx_r   <= '0;
      kfound_r <= 1'b0;
      kamt_r   <= '0;
    end else begin
      st_r     <= st_nxt;
      kidx_r   <= kidx_nxt;
      kfound_r <= kfound_nxt;
      kamt_r   <= kamt_nxt;
    end
  end

  // Pen, string state, glyph valid bits and kerning count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gvalid_r  <= '0;
      kcnt_r    <= '0;
      pen_x_r   <= '0;
      pen_y_r   <= '0;
      prev_r    <= '0;
      prev_ok_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      if (gwr) gvalid_r[q_item.code] <= 1'b1;
      if (kwr) kcnt_r <= kcnt_r + 1'b1;
      if ((st_r == ST_IDLE) && q_valid && (kind_t'(q_item.kind) == KIND_BEGIN)) begin
        pen_x_r   <= 24'(q_item.position_x);
        pen_y_r   <= 18'(q_item.position_y) + 18'(line_h_r);
        prev_ok_r <= 1'b0;
        prev_r    <= '0;
        cnt_r     <= '0;
      end
      if (st_r == ST_MUL) begin
        // The pen already holds the kerned position here; only the advance is added.
        pen_x_r   <= sat24(42'(pen_x_r) + 42'($signed({1'b0, g_adv})));
        prev_r    <= q_item.code;
        prev_ok_r <= 1'b1;
        cnt_r     <= cnt_r + 1'b1;
      end else if (st_r == ST_CALC) begin
        pen_x_r <= pen_a[23:0];
      end
    end
  end

  // Edge computation before scaling (pen already holds kerning in ST_MUL).
  always_ff @(posedge clk) begin
    if (st_r == ST_CALC) begin
      lft_r <= pen_a + 25'(g_ox);
      rgt_r <= pen_a + 25'(g_ox) + 25'(g_w);
      top_r <= 19'(pen_y_r) - 19'(g_oy);
      bot_r <= 19'(pen_y_r) - 19'(g_oy) - 19'(g_h);
      tl_r  <= 13'(g_ax);
      tr_r  <= 13'(g_ax) + 13'(g_w);
      tt_r  <= 13'(g_ay);
      tb_r  <= 13'(g_ay) + 13'(g_h);
    end
  end

  // Scaling multipliers into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (st_r == ST_MUL) begin
      out_v_r <= 1'b1;
    end else if (res_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_MUL) begin
      out_r.quad_left    <= sat24(42'(lft_r) * $signed({1'b0, scale_r}));
      out_r.quad_right   <= sat24(42'(rgt_r) * $signed({1'b0, scale_r}));
      out_r.quad_top     <= sat24(42'(top_r) * $signed({1'b0, scale_r}));
      out_r.quad_bottom  <= sat24(42'(bot_r) * $signed({1'b0, scale_r}));
      out_r.tex_left     <= sat_tex(29'(tl_r) * 29'(inv_r));
      out_r.tex_right    <= sat_tex(29'(tr_r) * 29'(inv_r));
      out_r.tex_top      <= sat_tex(29'(tt_r) * 29'(inv_r));
      out_r.tex_bottom   <= sat_tex(29'(tb_r) * 29'(inv_r));
      out_r.glyph_number <= cnt_r;
    end
  end

  assign res_valid = out_v_r;
  assign res_data  = out_r;

endmodule

// ----- rtl/glyph_quad_layout_with_kerning_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_quad_layout_with_kerning_core: text layout engine top level.
// Channel  | dir | payload
// in       | in  | item_t command (load, kern pair, begin, place)
// out      | out | result_t quad, texture rectangle, glyph number
// cfg      | in  | write enable, index, 16-bit data
// Load, kern and begin items retire straight from idle. A place item runs
// the serial kerning search over n, the number of kerning pairs scanned,
// reading and comparing one entry of the kerning memory at a time.
// Reset is synchronous; glyph entries read as zero until loaded.
// A two-entry queue decouples intake from execution; the result register
// holds until taken, and a place item waits for it to free.
// ----------------------------------------------------------------------------
module glyph_quad_layout_with_kerning_core import gql_pkg::*; (
  input logic clk,
  input logic rst_n,
  gql_stream_if.sink   in_s,
  gql_stream_if.source out_s,
  input logic                cfg_we,
  input logic [CfgIdxW-1:0]  cfg_index,
  input logic [CfgDataW-1:0] cfg_data
);

  logic  q_valid, q_pop;
  item_t q_item;

  gql_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_s.valid),
    .in_ready(in_s.ready),
    .in_item (in_s.data),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item)
  );

  gql_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .res_valid(out_s.valid),
    .res_ready(out_s.ready),
    .res_data (out_s.data)
  );

endmodule

// ----- tb/sv/tb_glyph_quad_layout_with_kerning_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_quad_layout_with_kerning_core: self-checking glyph layout bench.
// A queue-fed driver pushes load, kerning, begin and place items into the
// layout core, and an independent layout predictor works out every quad and
// texture rectangle. A monitor compares each result field by field. Phases
// vary the registers and the amount of idling on both channels.
// ----------------------------------------------------------------------------
module tb_glyph_quad_layout_with_kerning_core;
  import gql_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int Settle = 16;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  gql_stream_if #(.payload_t(item_t))   in_if ();
  gql_stream_if #(.payload_t(result_t)) out_if ();

  glyph_quad_layout_with_kerning_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_if.sink),
    .out_s     (out_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock with an 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Layout predictor state.
  logic [15:0]       scale_reg;
  logic [15:0]       inv_atlas_reg;
  logic [7:0]        line_height_reg;
  logic [11:0]       g_ax [GlyphEntries];
  logic [11:0]       g_ay [GlyphEntries];
  logic [7:0]        g_w [GlyphEntries];
  logic [7:0]        g_h [GlyphEntries];
  logic signed [7:0] g_ox [GlyphEntries];
  logic signed [7:0] g_oy [GlyphEntries];
  logic [7:0]        g_adv [GlyphEntries];
  logic [7:0]        pair_first [KernEntries];
  logic [7:0]        pair_second [KernEntries];
  logic signed [7:0] pair_amount [KernEntries];
  int                pair_count;
  longint            pen_x;
  longint            pen_y;
  logic [7:0]        last_code;
  logic              last_valid;
  logic [15:0]       glyph_index;

  item_t   pending_items[$];
  result_t layout_q[$];
  int      errors;
  int      snd_idle_pct;
  int      rcv_stall_pct;
  logic    hold_rx;

  // Append an item to the tail of the pending queue.
  task automatic queue_item(input item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic longint clamp_pen(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic logic [23:0] scaled_quad(input longint pix);
    longint v;
    v = clamp_pen(pix * longint'(scale_reg));
    return v[23:0];
  endfunction

  function automatic logic [16:0] scaled_tex(input longint pix);
    longint v;
    v = pix * longint'(inv_atlas_reg);
    return (v > 131071) ? TexMax : v[16:0];
  endfunction

  // First matching pair in append order wins.
  function automatic longint pair_kerning(input logic [7:0] a, input logic [7:0] b);
    for (int j = 0; j < pair_count; j++)
      if (pair_first[j] == a && pair_second[j] == b) return longint'(pair_amount[j]);
    return 0;
  endfunction

  // Advance the predictor by one accepted item.
  task automatic predict_layout(input item_t it);
    result_t r;
    longint left, top;
    logic [7:0] c;
    c = it.code;
    case (kind_t'(it.kind))
      KIND_LOAD: begin
        g_ax[c] = it.position_x[11:0];
        g_ay[c] = it.position_y[11:0];
        g_w[c] = it.glyph_width;
        g_h[c] = it.glyph_height;
        g_ox[c] = it.offset_x;
        g_oy[c] = it.offset_y;
        g_adv[c] = it.advance;
      end
      KIND_KERN: begin
        if (pair_count < KernEntries) begin
          pair_first[pair_count] = it.code;
          pair_second[pair_count] = it.second_code;
          pair_amount[pair_count] = it.kern_amount;
          pair_count++;
        end
      end
      KIND_BEGIN: begin
        pen_x = longint'(it.position_x);
        pen_y = longint'(it.position_y) + longint'(line_height_reg);
        last_valid = 1'b0;
        last_code = '0;
        glyph_index = '0;
      end
      default: begin
        if (last_valid) pen_x = clamp_pen(pen_x + pair_kerning(last_code, c));
        left = pen_x + longint'(g_ox[c]);
        top = pen_y - longint'(g_oy[c]);
        r.quad_left = scaled_quad(left);
        r.quad_right = scaled_quad(left + longint'(g_w[c]));
        r.quad_top = scaled_quad(top);
        r.quad_bottom = scaled_quad(top - longint'(g_h[c]));
        r.tex_left = scaled_tex(longint'(g_ax[c]));
        r.tex_right = scaled_tex(longint'(g_ax[c]) + longint'(g_w[c]));
        r.tex_top = scaled_tex(longint'(g_ay[c]));
        r.tex_bottom = scaled_tex(longint'(g_ay[c]) + longint'(g_h[c]));
        r.glyph_number = glyph_index;
        layout_q.insert(layout_q.size(), r);
        pen_x = clamp_pen(pen_x + longint'(g_adv[c]));
        last_code = c;
        last_valid = 1'b1;
        glyph_index = glyph_index + 16'd1;
      end
    endcase
  endtask

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string nm, input logic [23:0] got,
                             input logic [23:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", nm, got, want));
  endtask

  // Sender side: keep valid and data stable until the item is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_layout(in_if.data);
        void'(pending_items.pop_front());
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.data <= pending_items[0];
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver side: random stalls, long hold-off, and result checking.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (layout_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = layout_q.pop_front();
          check_field("quad_left", out_if.data.quad_left, want.quad_left);
          check_field("quad_right", out_if.data.quad_right, want.quad_right);
          check_field("quad_top", out_if.data.quad_top, want.quad_top);
          check_field("quad_bottom", out_if.data.quad_bottom, want.quad_bottom);
          check_field("tex_left", 24'(out_if.data.tex_left), 24'(want.tex_left));
          check_field("tex_right", 24'(out_if.data.tex_right), 24'(want.tex_right));
          check_field("tex_top", 24'(out_if.data.tex_top), 24'(want.tex_top));
          check_field("tex_bottom", 24'(out_if.data.tex_bottom), 24'(want.tex_bottom));
          check_field("glyph_number", 24'(out_if.data.glyph_number),
                      24'(want.glyph_number));
        end
      end
      out_if.ready <= !hold_rx && ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  // Random base so that fields a command ignores still toggle.
  function automatic item_t rand_base();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return item_t'(raw[$bits(item_t)-1:0]);
  endfunction

  function automatic item_t mk_load(input logic [7:0] c, input logic [15:0] px,
                                    input logic [15:0] py, input logic [7:0] w,
                                    input logic [7:0] h, input logic [7:0] ox,
                                    input logic [7:0] oy, input logic [7:0] adv);
    item_t it;
    it = rand_base();
    it.kind = KIND_LOAD;
    it.code = c;
    it.position_x = px;
    it.position_y = py;
    it.glyph_width = w;
    it.glyph_height = h;
    it.offset_x = ox;
    it.offset_y = oy;
    it.advance = adv;
    return it;
  endfunction

  function automatic item_t mk_kern(input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] amt);
    item_t it;
    it = rand_base();
    it.kind = KIND_KERN;
    it.code = a;
    it.second_code = b;
    it.kern_amount = amt;
    return it;
  endfunction

  function automatic item_t mk_begin(input logic [15:0] x, input logic [15:0] y);
    item_t it;
    it = rand_base();
    it.kind = KIND_BEGIN;
    it.position_x = x;
    it.position_y = y;
    return it;
  endfunction

  function automatic item_t mk_place(input logic [7:0] c);
    item_t it;
    it = rand_base();
    it.kind = KIND_PLACE;
    it.code = c;
    return it;
  endfunction

  // Mostly a small pool of codes so that kerning pairs actually match.
  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return 8'($urandom_range(60, 71));
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SCALE:       scale_reg = v;
      CFG_INV_ATLAS:   inv_atlas_reg = v;
      CFG_LINE_HEIGHT: line_height_reg = v[7:0];
      default: ;
    endcase
  endtask

  // Block until every item is taken and every result has come back.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() > 0 || in_if.valid || layout_q.size() > 0);
    repeat (Settle) @(posedge clk);
  endtask

  // One well-formed string with some noise mixed in.
  task automatic push_string(inout int pushed);
    int n;
    queue_item(($urandom_range(0, 3) == 0)
      ? mk_begin(16'($urandom), 16'($urandom))
      : mk_begin(16'($urandom_range(0, 600)), 16'($urandom_range(0, 400))));
    pushed++;
    n = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0, 1: queue_item(mk_load(pick_code(), 16'($urandom),
                16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom)));
        2: queue_item(mk_kern(pick_code(), pick_code(), 8'($urandom)));
        3: queue_item(($urandom_range(0, 1) == 0) ? rand_base()
                      : mk_place(pick_code()));
        default: queue_item(mk_place(pick_code()));
      endcase
      pushed++;
    end
  endtask

  // Stimulus sequence.
  initial begin
    int pushed;
    pending_items.delete();
    layout_q.delete();
    errors = 0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_rx = 1'b0;
    scale_reg = 16'd256;
    inv_atlas_reg = 16'd256;
    line_height_reg = 8'd0;
    for (int i = 0; i < GlyphEntries; i++) begin
      g_ax[i] = '0; g_ay[i] = '0; g_w[i] = '0; g_h[i] = '0;
      g_ox[i] = '0; g_oy[i] = '0; g_adv[i] = '0;
    end
    pair_count = 0;
    pen_x = 0;
    pen_y = 0;
    last_code = '0;
    last_valid = 1'b0;
    glyph_index = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Place before any begin, with unknown glyphs, while the kerning table
    // is still empty.
    for (int i = 0; i < 24; i++) queue_item(mk_place(8'(i % 3)));
    wait_drained();

    // Directed: field extremes, duplicate pairs, first character, no glyph.
    queue_item(mk_load(8'd65, 16'hFFFF, 16'h8000, 8'd255, 8'd255,
                       8'h80, 8'h7F, 8'd255));
    queue_item(mk_load(8'd66, 16'h0010, 16'h7FFF, 8'd7, 8'd9,
                       8'h7F, 8'h80, 8'd0));
    queue_item(mk_load(8'd255, 16'h0FFF, 16'h0FFF, 8'd1, 8'd2,
                       8'd1, 8'd2, 8'd3));
    queue_item(mk_kern(8'd65, 8'd66, 8'h80));
    queue_item(mk_kern(8'd65, 8'd66, 8'd5));
    queue_item(mk_kern(8'd66, 8'd65, 8'h7F));
    queue_item(mk_kern(8'd255, 8'd0, 8'h01));
    queue_item(mk_begin(16'h8000, 16'h7FFF));
    queue_item(mk_place(8'd65));
    queue_item(mk_place(8'd66));
    queue_item(mk_place(8'd65));
    queue_item(mk_place(8'd200));
    queue_item(mk_place(8'd255));
    queue_item(mk_place(8'd0));
    queue_item(mk_begin(16'h7FFF, 16'h8000));
    queue_item(mk_place(8'd66));
    queue_item(mk_place(8'd65));
    wait_drained();

    // Largest registers: quads and textures saturate.
    write_reg(CFG_SCALE, 16'hFFFF);
    write_reg(CFG_INV_ATLAS, 16'hFFFF);
    write_reg(CFG_LINE_HEIGHT, 16'h00FF);
    write_reg(CfgUnused, 16'h1234);
    queue_item(mk_begin(16'h7FFF, 16'h7FFF));
    queue_item(mk_place(8'd65));
    queue_item(mk_place(8'd66));
    queue_item(mk_begin(16'h8000, 16'h8000));
    queue_item(mk_place(8'd255));
    wait_drained();

    // Zero registers give zero quads and texture coordinates.
    write_reg(CFG_SCALE, 16'h0000);
    write_reg(CFG_INV_ATLAS, 16'h0000);
    write_reg(CFG_LINE_HEIGHT, 16'h0000);
    queue_item(mk_place(8'd65));
    wait_drained();
    write_reg(CFG_SCALE, 16'd1);
    write_reg(CFG_INV_ATLAS, 16'd1);
    queue_item(mk_place(8'd255));
    wait_drained();

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      snd_idle_pct = (ph == 1) ? 55 : (ph == 3) ? 12 : 0;
      rcv_stall_pct = (ph == 2) ? 55 : (ph == 3) ? 12 : 0;
      write_reg(CFG_SCALE, ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 65535))
                                                       : 16'($urandom_range(64, 512)));
      write_reg(CFG_INV_ATLAS, 16'($urandom_range(1, 65535)));
      write_reg(CFG_LINE_HEIGHT, 16'($urandom_range(0, 255)));
      pushed = 0;
      if (ph == 2) begin
        // Long receiver hold-off while the sender keeps offering items.
        @(posedge clk);
        hold_rx <= 1'b1;
        fork
          begin
            repeat (600) @(posedge clk);
            hold_rx <= 1'b0;
          end
        join_none
      end
      while (pushed < 200) begin
        push_string(pushed);
        // Occasionally let the sender pause until all results are back.
        if ($urandom_range(0, 15) == 0) wait_drained();
        else @(posedge clk);
      end
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
